@@ hw/rtl/mcahr_pkg.sv @@
// Package for the multi-channel attack/hold/release gain tracker.
// Holds field widths, reset values, register indexes, the bank entry type and a unity clamp.
// No dependencies.
`default_nettype none

package mcahr_pkg;

  localparam int IDX_W   = 5;
  localparam int GAIN_W  = 16;
  localparam int FREQ_W  = 19;
  localparam int Q_W     = 13;
  localparam int HOLD_W  = 16;
  localparam int STEP_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 72;

  localparam int NUM_FILTERS_DEF = 32;
  localparam int Q_MIN_DEF       = 512;
  localparam int Q_MAX_DEF       = 6144;

  localparam logic [GAIN_W-1:0] UNITY      = 16'd32768;
  localparam logic [GAIN_W-1:0] PEAK_MIN   = 16'd328;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 19'd16000;
  localparam logic [GAIN_W+15:0] ROUND_HALF = 32'd16384;

  localparam logic [15:0]     ATTACK_RST   = 16'd32000;
  localparam logic [15:0]     RELEASE_RST  = 16'd32700;
  localparam logic [15:0]     HOLD_RST     = 16'd0;
  localparam logic [FREQ_W-1:0] FREQ_LOW_RST  = 19'd320;
  localparam logic [FREQ_W-1:0] FREQ_HIGH_RST = 19'd364800;
  localparam logic [15:0]     FREQ_STEP_RST = 16'd16;
  localparam logic [15:0]     GAIN_STEP_RST = 16'd33;
  localparam logic [Q_W-1:0]  Q_STEP_RST    = 13'd13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK    = 3'd0,
    REG_RELEASE   = 3'd1,
    REG_HOLD      = 3'd2,
    REG_FREQ_LOW  = 3'd3,
    REG_FREQ_HIGH = 3'd4,
    REG_FREQ_STEP = 3'd5,
    REG_GAIN_STEP = 3'd6,
    REG_Q_STEP    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [FREQ_W-1:0] freq;
    logic [Q_W-1:0]    q;
    logic [HOLD_W-1:0] hold;
  } bank_entry_t;

  function automatic logic [GAIN_W-1:0] sat_unity(input logic [GAIN_W-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/multi_channel_attack_hold_release.sv @@
// Attack/hold/release gain tracker with frequency and Q clamping for a filter bank.
// Per-filter state sits in a bank memory with valid bits; uses mcahr_pkg.
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tdata: filter_index, target_gain, target_freq, target_q
//   m_axis    out  tvalid/tready        tdata: filter_id, gain_now, freq_now, q_now, peak_gain
//                                       tuser: refresh
//   cfg       in   cfg_we               cfg_index, cfg_data
//
// One item per cycle is accepted while the output is not stalled. The accepting edge loads
// the input register and reads the filter's entry from the bank memory; while the item sits
// there the smoothing multiply, clamps and compares run, and the edge on which it advances
// registers the result in the output register and writes the entry back.
// A write-back in the cycle an item is read is forwarded to that item.
// Reset marks every bank entry as holding its reset value; no clearing pass is needed.
// A stalled output holds one result while one more item waits in the input register.
`default_nettype none

module multi_channel_attack_hold_release
  import mcahr_pkg::*;
#(
  parameter int NUM_FILTERS = NUM_FILTERS_DEF,
  parameter int Q_MIN       = Q_MIN_DEF,
  parameter int Q_MAX       = Q_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [4:0] filter_index, [20:5] target_gain, [39:21] target_freq, [52:40] target_q
  input  wire logic [S_DATA_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [4:0] filter_id, [20:5] gain_now, [39:21] freq_now, [52:40] q_now, [68:53] peak_gain
  output logic [M_DATA_W-1:0]        m_axis_tdata,
  // [0] refresh
  output logic [0:0]                 m_axis_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam logic [Q_W-1:0] QMIN_V = Q_W'(Q_MIN);
  localparam logic [Q_W-1:0] QMAX_V = Q_W'(Q_MAX);
  localparam bank_entry_t RESET_ENTRY = '{gain: UNITY, freq: FREQ_RESET, q: QMIN_V,
                                          hold: '0};

  // Configuration registers.
  logic [15:0]       attack_coeff;
  logic [15:0]       release_coeff;
  logic [15:0]       hold_samples;
  logic [FREQ_W-1:0] freq_low;
  logic [FREQ_W-1:0] freq_high;
  logic [STEP_W-1:0] freq_step;
  logic [STEP_W-1:0] gain_step;
  logic [Q_W-1:0]    q_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff  <= ATTACK_RST;
      release_coeff <= RELEASE_RST;
      hold_samples  <= HOLD_RST;
      freq_low      <= FREQ_LOW_RST;
      freq_high     <= FREQ_HIGH_RST;
      freq_step     <= FREQ_STEP_RST;
      gain_step     <= GAIN_STEP_RST;
      q_step        <= Q_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATTACK:    attack_coeff  <= cfg_data[15:0];
        REG_RELEASE:   release_coeff <= cfg_data[15:0];
        REG_HOLD:      hold_samples  <= cfg_data[15:0];
        REG_FREQ_LOW:  freq_low      <= cfg_data;
        REG_FREQ_HIGH: freq_high     <= cfg_data;
        REG_FREQ_STEP: freq_step     <= cfg_data[15:0];
        REG_GAIN_STEP: gain_step     <= cfg_data[15:0];
        REG_Q_STEP:    q_step        <= cfg_data[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // Input unpacking.
  logic [IDX_W-1:0]  in_idx;
  logic [GAIN_W-1:0] in_gain;
  logic [FREQ_W-1:0] in_freq;
  logic [Q_W-1:0]    in_q;
  logic [ADDR_W-1:0] in_addr;
  logic              in_ok;
  logic              in_fire;

  assign in_idx  = s_axis_tdata[4:0];
  assign in_gain = s_axis_tdata[20:5];
  assign in_freq = s_axis_tdata[39:21];
  assign in_q    = s_axis_tdata[52:40];
  assign in_addr = ADDR_W'(in_idx);
  assign in_ok   = (32'(in_idx) < NUM_FILTERS);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Bank memory and valid bits.
  bank_entry_t          bank [NUM_FILTERS];
  logic [NUM_FILTERS-1:0] bank_valid;

  // Stage 1: input register plus registered bank read.
  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_ok;
  logic [GAIN_W-1:0] s1_gain;
  logic [FREQ_W-1:0] s1_freq;
  logic [Q_W-1:0]    s1_q;
  bank_entry_t       rd_entry;
  logic              rd_valid;
  logic              fwd_hit;
  bank_entry_t       fwd_entry;
  logic              s1_adv;
  logic              wr_en;
  bank_entry_t       wr_entry;

  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign wr_en         = s1_adv && s1_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx    <= in_idx;
      s1_addr   <= in_addr;
      s1_ok     <= in_ok;
      s1_gain   <= sat_unity(in_gain);
      s1_freq   <= in_freq;
      s1_q      <= in_q;
      rd_entry  <= bank[in_addr];
      rd_valid  <= bank_valid[in_addr];
      fwd_hit   <= wr_en && (s1_addr == in_addr);
      fwd_entry <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[s1_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= '0;
    end else if (wr_en) begin
      bank_valid[s1_addr] <= 1'b1;
    end
  end

  // Stage 1 datapath.
  bank_entry_t              cur;
  logic                     attack;
  logic [GAIN_W-1:0]        weight;
  logic signed [GAIN_W:0]   gdiff;
  logic signed [GAIN_W+17:0] acc;
  logic [GAIN_W-1:0]        smoothed;
  logic [GAIN_W-1:0]        gain_new;
  logic [HOLD_W-1:0]        hold_new;
  logic [FREQ_W-1:0]        freq_new;
  logic [Q_W-1:0]           q_new;
  logic [GAIN_W-1:0]        gain_d;
  logic [FREQ_W-1:0]        freq_d;
  logic [Q_W-1:0]           q_d;
  logic                     upd;
  logic [GAIN_W-1:0]        peak;

  always_comb begin
    cur = fwd_hit ? fwd_entry : (rd_valid ? rd_entry : RESET_ENTRY);
    attack = (s1_gain < cur.gain);
    weight = attack ? sat_unity(attack_coeff) : sat_unity(release_coeff);
    // cur*w + tgt*(1-w) rewritten as tgt + (cur-tgt)*w, one multiply.
    gdiff = $signed({1'b0, cur.gain}) - $signed({1'b0, s1_gain});
    acc = $signed({3'b000, s1_gain, 15'd0}) + gdiff * $signed({1'b0, weight})
        + $signed({2'b00, ROUND_HALF});
    smoothed = acc[GAIN_W+14:15];

    if (attack) begin
      gain_new = smoothed;
      hold_new = hold_samples;
    end else if (cur.hold != '0) begin
      gain_new = cur.gain;
      hold_new = cur.hold - HOLD_W'(1);
    end else begin
      gain_new = smoothed;
      hold_new = cur.hold;
    end

    if (s1_freq < freq_low) begin
      freq_new = freq_low;
    end else if (freq_high < s1_freq) begin
      freq_new = freq_high;
    end else begin
      freq_new = s1_freq;
    end

    if (s1_q < QMIN_V) begin
      q_new = QMIN_V;
    end else if (QMAX_V < s1_q) begin
      q_new = QMAX_V;
    end else begin
      q_new = s1_q;
    end

    gain_d = (gain_new > cur.gain) ? gain_new - cur.gain : cur.gain - gain_new;
    freq_d = (freq_new > cur.freq) ? freq_new - cur.freq : cur.freq - freq_new;
    q_d    = (q_new > cur.q) ? q_new - cur.q : cur.q - q_new;
    upd = (freq_d > FREQ_W'(freq_step)) || (gain_d > gain_step) || (q_d > q_step);

    wr_entry.gain = upd ? gain_new : cur.gain;
    wr_entry.freq = upd ? freq_new : cur.freq;
    wr_entry.q    = upd ? q_new : cur.q;
    wr_entry.hold = hold_new;

    if (wr_entry.gain < PEAK_MIN) begin
      peak = PEAK_MIN;
    end else if (wr_entry.gain > UNITY) begin
      peak = UNITY;
    end else begin
      peak = wr_entry.gain;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_axis_tdata[4:0]   <= s1_idx;
      m_axis_tdata[20:5]  <= s1_ok ? wr_entry.gain : '0;
      m_axis_tdata[39:21] <= s1_ok ? wr_entry.freq : '0;
      m_axis_tdata[52:40] <= s1_ok ? wr_entry.q : '0;
      m_axis_tdata[68:53] <= s1_ok ? peak : '0;
      m_axis_tdata[71:69] <= '0;
      m_axis_tuser[0]     <= s1_ok && upd;
    end
  end

  // Assertions.
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (32'(m_axis_tdata[4:0]) >= NUM_FILTERS)) |->
      (m_axis_tdata[68:5] == '0) && !m_axis_tuser[0])
    else $error("out-of-range result carries nonzero fields");

  a_peak_bounds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (32'(m_axis_tdata[4:0]) < NUM_FILTERS)) |->
      (m_axis_tdata[68:53] >= PEAK_MIN) && (m_axis_tdata[68:53] <= UNITY))
    else $error("peak gain outside its bounds");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_idx) && $stable(s1_gain)))
    else $error("stalled item lost in input register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_axis_tready)
    else $error("input refused while input register empty");

endmodule

`default_nettype wire
